// ===== design/upi_pkg.sv =====
// Shared types, constants and the arctangent table of the pose integrator.
// Used by the CORDIC, the divider and the top level; depends on nothing.
package upi_pkg;

   localparam logic signed [33:0] CORDIC_GAIN    = 34'sd652032874;
   localparam logic signed [33:0] Q30_ONE        = 34'sd1073741824;
   localparam logic [32:0]        DEG_TO_RAD     = 33'd18740330;
   localparam int unsigned        STRAIGHT_LIMIT = 6835;
   localparam int unsigned        NUM_W          = 64;
   localparam int unsigned        DEN_W          = 48;

   typedef struct packed {
      logic               done;
      logic signed [31:0] sin_q30;
      logic signed [31:0] cos_q30;
   } cordic_out_type;

   typedef struct packed {
      logic              done;
      logic [NUM_W-1:0]  quot;
   } div_out_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [29:0] atan_turn(input logic [4:0] idx);
      logic [29:0] r;
      case (idx)
         5'd0:  r = 30'd536870912;
         5'd1:  r = 30'd316933406;
         5'd2:  r = 30'd167458907;
         5'd3:  r = 30'd85004756;
         5'd4:  r = 30'd42667331;
         5'd5:  r = 30'd21354465;
         5'd6:  r = 30'd10679838;
         5'd7:  r = 30'd5340245;
         5'd8:  r = 30'd2670163;
         5'd9:  r = 30'd1335087;
         5'd10: r = 30'd667544;
         5'd11: r = 30'd333772;
         5'd12: r = 30'd166886;
         5'd13: r = 30'd83443;
         5'd14: r = 30'd41722;
         5'd15: r = 30'd20861;
         5'd16: r = 30'd10430;
         5'd17: r = 30'd5215;
         5'd18: r = 30'd2608;
         5'd19: r = 30'd1304;
         5'd20: r = 30'd652;
         5'd21: r = 30'd326;
         5'd22: r = 30'd163;
         5'd23: r = 30'd81;
         5'd24: r = 30'd41;
         5'd25: r = 30'd20;
         5'd26: r = 30'd10;
         5'd27: r = 30'd5;
         5'd28: r = 30'd3;
         5'd29: r = 30'd1;
         5'd30: r = 30'd1;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== design/upi_cordic.sv =====
// Iterative CORDIC: sine and cosine of a binary angle, one rotation a cycle.
// Depends on upi_pkg for the gain, the clamp limit and the arctangent table.
module upi_cordic import upi_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [31:0]    angle,
   output cordic_out_type result
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic               neg_ff, neg_in;

   logic [31:0]        sum_q, ang_fold;
   logic signed [33:0] x_sh, y_sh, at, x_out, y_out;

   function automatic logic signed [31:0] clamp(input logic signed [33:0] v);
      logic signed [33:0] r;
      r = v;
      if (v > Q30_ONE) r = Q30_ONE;
      if (v < -Q30_ONE) r = -Q30_ONE;
      return r[31:0];
   endfunction

   always_comb begin
      sum_q    = angle + 32'h4000_0000;
      ang_fold = sum_q[31] ? angle + 32'h8000_0000 : angle;
      x_sh     = x_ff >>> cnt_ff;
      y_sh     = y_ff >>> cnt_ff;
      at       = {4'b0, atan_turn(cnt_ff)};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      neg_in   = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         x_in    = CORDIC_GAIN;
         y_in    = 34'sd0;
         z_in    = {{2{ang_fold[31]}}, ang_fold};
         neg_in  = sum_q[31];
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      // undo the half-turn fold
      x_out = neg_ff ? -x_ff : x_ff;
      y_out = neg_ff ? -y_ff : y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign result.done    = done_ff;
   assign result.sin_q30 = clamp(y_out);
   assign result.cos_q30 = clamp(x_out);

endmodule

// ===== design/upi_divider.sv =====
// Restoring divider, unsigned, one quotient bit a cycle.
// Depends on upi_pkg for the operand widths and the result struct.
module upi_divider import upi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output div_out_type      result
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial, diff;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign result.done = done_ff;
   assign result.quot = quo_ff;

endmodule

// ===== design/unicycle_pose_integrator.sv =====
// Planar pose integrator: request sequencer, shared multiplier and pose state.
// Depends on upi_pkg, upi_cordic and upi_divider.
//
// A request on req_ carries an operation (tuser) and the linear speed and
// turn rate (tdata). Operation 0 advances the pose by one time step, 1 zeroes
// it. Each request gives exactly one response on rsp_ with the new pose and a
// saturation flag. The time step is written through csr_wen / csr_wdata.
// One request is worked on at a time; req_tready is high only while idle.
// Work per request: a pose reset needs no arithmetic; a straight move takes
// one division for the heading increment and one CORDIC pass; an arc move
// adds a second CORDIC pass and two more divisions. All work runs through
// one multiplier, one divider and one CORDIC unit in turn. A response waits
// in place while rsp_tready is low; the next request is then accepted and
// worked on, and its response is held back until the previous one is taken.
// Reset clears the pose, sets the time step to 655 and drops any pending
// response.
module unicycle_pose_integrator import upi_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // linear_speed[15:0], turn_rate[39:16]
   input  logic [0:0]  req_tuser,   // operation[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // pos_x[31:0], pos_y[63:32], heading[95:64]
   output logic [0:0]  rsp_tuser,   // saturated[0]
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_MWD  = 5'd1;
   localparam logic [4:0] S_MVD  = 5'd2;
   localparam logic [4:0] S_DTH  = 5'd3;
   localparam logic [4:0] S_DTHW = 5'd4;
   localparam logic [4:0] S_COR0 = 5'd5;
   localparam logic [4:0] S_STRX = 5'd6;
   localparam logic [4:0] S_STRY = 5'd7;
   localparam logic [4:0] S_STRE = 5'd8;
   localparam logic [4:0] S_COR1 = 5'd9;
   localparam logic [4:0] S_ARC0 = 5'd10;
   localparam logic [4:0] S_ARC1 = 5'd11;
   localparam logic [4:0] S_ARC2 = 5'd12;
   localparam logic [4:0] S_ARC3 = 5'd13;
   localparam logic [4:0] S_ARC4 = 5'd14;
   localparam logic [4:0] S_ARC5 = 5'd15;
   localparam logic [4:0] S_FIN  = 5'd16;

   logic [4:0]         state_ff, state_in;
   logic [15:0]        step_ff, step_in;
   logic               op_ff, op_in, arc_ff, arc_in, nneg_ff, nneg_in;
   logic               sat_ff, sat_in, valid_ff, valid_in;
   logic signed [15:0] v_ff, v_in;
   logic signed [23:0] w_ff, w_in;
   logic signed [40:0] wdt_ff, wdt_in;
   logic signed [31:0] d_ff, d_in;
   logic signed [45:0] dth_ff, dth_in;
   logic signed [31:0] s0_ff, s0_in, c0_ff, c0_in, s1_ff, s1_in, c1_ff, c1_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic signed [63:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [31:0]        px_ff, px_in, py_ff, py_in, hd_ff, hd_in;
   logic signed [65:0] prod_ff;

   logic signed [32:0] mul_a, mul_b;
   logic [23:0]        abs_w;
   logic signed [45:0] wdt32, mag46, abs_dth;
   logic [63:0]        nump, magp;
   logic               cor_start, div_start, free, w_neg;
   logic [31:0]        cor_angle;
   logic [NUM_W-1:0]   div_num;
   logic [DEN_W-1:0]   div_den;
   logic [32:0]        sx, sy;
   cordic_out_type     cor;
   div_out_type        div;

   // round half away from zero of a product over 2^38
   function automatic logic signed [63:0] rnd38(input logic signed [65:0] p);
      logic signed [63:0] q, m, r;
      q = p[63:0];
      m = q[63] ? -q : q;
      r = (m + 64'sd137438953472) >>> 38;
      return q[63] ? -r : r;
   endfunction

   function automatic logic signed [63:0] signed_q(input logic [63:0] q, input logic neg);
      return neg ? -$signed(q) : $signed(q);
   endfunction

   // {clipped, value}
   function automatic logic [32:0] sat32(input logic [31:0] pos, input logic signed [63:0] dl);
      logic signed [64:0] s;
      logic               c;
      s = {{33{pos[31]}}, pos} + {dl[63], dl};
      c = 1'b0;
      if (s > 65'sd2147483647) begin
         s = 65'sd2147483647;
         c = 1'b1;
      end
      if (s < -65'sd2147483648) begin
         s = -65'sd2147483648;
         c = 1'b1;
      end
      return {c, s[31:0]};
   endfunction

   upi_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cor_start),
      .angle  (cor_angle),
      .result (cor)
   );

   upi_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .result (div)
   );

   always_comb begin
      abs_w   = w_ff[23] ? 24'(-w_ff) : 24'(w_ff);
      w_neg   = w_ff[23];
      wdt32   = {wdt_ff, 5'b0};
      mag46   = wdt32[45] ? -wdt32 : wdt32;
      abs_dth = dth_ff[45] ? -dth_ff : dth_ff;
      nump    = {prod_ff[47:0], 16'b0};
      magp    = prod_ff[65] ? -nump : nump;
      free    = !valid_ff || rsp_tready;

      unique case (state_ff)
         S_MWD:   begin mul_a = 33'(w_ff);             mul_b = $signed({17'b0, step_ff}); end
         S_MVD:   begin mul_a = 33'(v_ff);             mul_b = $signed({17'b0, step_ff}); end
         S_STRX:  begin mul_a = 33'(d_ff);             mul_b = 33'(s0_ff); end
         S_STRY:  begin mul_a = 33'(d_ff);             mul_b = 33'(c0_ff); end
         S_ARC0:  begin mul_a = $signed({9'b0, abs_w}); mul_b = $signed(DEG_TO_RAD); end
         S_ARC1:  begin mul_a = 33'(v_ff);             mul_b = 33'(c1_ff) - 33'(c0_ff); end
         default: begin mul_a = 33'(v_ff);             mul_b = 33'(s1_ff) - 33'(s0_ff); end
      endcase

      if (state_ff == S_DTH) begin
         div_num = {18'b0, mag46} + 64'd22;
         div_den = DEN_W'(45);
      end else begin
         div_num = magp + {17'b0, den_ff[DEN_W-1:1]};
         div_den = den_ff;
      end

      sx = sat32(px_ff, dx_ff);
      sy = sat32(py_ff, dy_ff);

      state_in  = state_ff;
      step_in   = csr_wen ? csr_wdata : step_ff;
      op_in     = op_ff;
      arc_in    = arc_ff;
      nneg_in   = nneg_ff;
      sat_in    = sat_ff;
      valid_in  = valid_ff && !rsp_tready;
      v_in      = v_ff;
      w_in      = w_ff;
      wdt_in    = wdt_ff;
      d_in      = d_ff;
      dth_in    = dth_ff;
      s0_in     = s0_ff;
      c0_in     = c0_ff;
      s1_in     = s1_ff;
      c1_in     = c1_ff;
      den_in    = den_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      hd_in     = hd_ff;
      cor_start = 1'b0;
      cor_angle = hd_ff;
      div_start = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser[0];
               v_in     = $signed(req_tdata[15:0]);
               w_in     = $signed(req_tdata[39:16]);
               arc_in   = 1'b0;
               state_in = req_tuser[0] ? S_FIN : S_MWD;
            end
         end
         S_MWD: state_in = S_MVD;
         S_MVD: begin
            wdt_in   = prod_ff[40:0];
            state_in = S_DTH;
         end
         S_DTH: begin
            d_in      = prod_ff[31:0];
            div_start = 1'b1;
            state_in  = S_DTHW;
         end
         S_DTHW: begin
            if (div.done) begin
               dth_in    = 46'(signed_q(div.quot, wdt_ff[40]));
               cor_start = 1'b1;
               state_in  = S_COR0;
            end
         end
         S_COR0: begin
            cor_angle = hd_ff + dth_ff[31:0];
            if (cor.done) begin
               s0_in = cor.sin_q30;
               c0_in = cor.cos_q30;
               if (w_ff == 24'sd0 || abs_dth < 46'(STRAIGHT_LIMIT)) begin
                  state_in = S_STRX;
               end else begin
                  cor_start = 1'b1;
                  arc_in    = 1'b1;
                  state_in  = S_COR1;
               end
            end
         end
         S_STRX: state_in = S_STRY;
         S_STRY: begin
            dx_in    = rnd38(prod_ff);
            state_in = S_STRE;
         end
         S_STRE: begin
            dy_in    = rnd38(prod_ff);
            state_in = S_FIN;
         end
         S_COR1: begin
            if (cor.done) begin
               s1_in    = cor.sin_q30;
               c1_in    = cor.cos_q30;
               state_in = S_ARC0;
            end
         end
         S_ARC0: state_in = S_ARC1;
         S_ARC1: begin
            den_in   = prod_ff[DEN_W-1:0];
            state_in = S_ARC2;
         end
         S_ARC2: begin
            nneg_in   = prod_ff[65];
            div_start = 1'b1;
            state_in  = S_ARC3;
         end
         S_ARC3: begin
            // x moves against the cosine change
            if (div.done) begin
               dx_in    = signed_q(div.quot, !nneg_ff ^ w_neg);
               state_in = S_ARC4;
            end
         end
         S_ARC4: begin
            nneg_in   = prod_ff[65];
            div_start = 1'b1;
            state_in  = S_ARC5;
         end
         S_ARC5: begin
            if (div.done) begin
               dy_in    = signed_q(div.quot, nneg_ff ^ w_neg);
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // hold until the previous response is taken
            if (free) begin
               valid_in = 1'b1;
               state_in = S_IDLE;
               if (op_ff) begin
                  px_in  = '0;
                  py_in  = '0;
                  hd_in  = '0;
                  sat_in = 1'b0;
               end else begin
                  px_in  = sx[31:0];
                  py_in  = sy[31:0];
                  sat_in = sx[32] | sy[32];
                  if (arc_ff) hd_in = hd_ff + dth_ff[31:0];
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= 16'd655;
         valid_ff <= 1'b0;
         px_ff    <= '0;
         py_ff    <= '0;
         hd_ff    <= '0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         hd_ff    <= hd_in;
         sat_ff   <= sat_in;
      end
      op_ff   <= op_in;
      arc_ff  <= arc_in;
      nneg_ff <= nneg_in;
      v_ff    <= v_in;
      w_ff    <= w_in;
      wdt_ff  <= wdt_in;
      d_ff    <= d_in;
      dth_ff  <= dth_in;
      s0_ff   <= s0_in;
      c0_ff   <= c0_in;
      s1_ff   <= s1_in;
      c1_ff   <= c1_in;
      den_ff  <= den_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      prod_ff <= mul_a * mul_b;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {hd_ff, py_ff, px_ff};
   assign rsp_tuser  = sat_ff;

endmodule

// ===== design/upi_checker.sv =====
// Port-level checks on the pose integrator, bound to the top level.
// Depends only on the top level's ports.
module upi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // a stalled response keeps its pose and flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // reset leaves the block idle with nothing pending
   a_reset: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

endmodule

bind unicycle_pose_integrator upi_checker u_upi_checker (.*);
